// File: rtl/rslm_pkg.sv
`timescale 1ns / 1ps
package rslm_pkg;

  localparam int MAX_SENDERS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [7:0]  OVERHEAD_RST = 8'd40;
  localparam logic [15:0] MAX_LEN_RST  = 16'd1500;
  localparam logic [21:0] KB_MAX       = 22'h3FFFFF;
  localparam int          KB_SHIFT     = 10;  // divide by 1024

  localparam logic CFG_IDX_OVERHEAD = 1'b0;
  localparam logic CFG_IDX_MAX_LEN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PKT,
    ST_TOTAL,
    ST_WALK
  } rslm_state_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic        pkt_en;     // apply the registered packet
    logic        miss;       // no cell holds the packet's address
    logic        shift_en;   // rotate the row one place toward cell 0
    logic [31:0] addr;
    logic [7:0]  seq;
    logic        seq_valid;
    logic [16:0] bytes;      // clamped length plus overhead
  } cell_ctl_t;

endpackage

// File: rtl/rtp_sender_loss_meter_core.sv
`timescale 1ns / 1ps
// Packet request: accepted when idle, applied to the cell row in the cycle after; requests stall until then.
// Tick request: optional total row, then a full rotation of the row;
//   rows leave one a cycle while the result side does not stall.
// Result rows sit in one output register; the walk pauses while that register is stalled.
// Reset (synchronous, rst_n low): slot table empty, grand totals zero, registers to defaults.
module rtp_sender_loss_meter_core import rslm_pkg::*; #(
  parameter int MAX_SENDERS = MAX_SENDERS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_source_addr,
  input  logic [7:0]  in_seq_byte,
  input  logic        in_seq_valid,
  input  logic [15:0] in_pkt_length,
  input  logic        in_new_minute,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_total_row,
  output logic        out_is_last,
  output logic [31:0] out_sender_addr,
  output logic [31:0] out_sec_packets,
  output logic [31:0] out_sec_lost,
  output logic [31:0] out_sec_late,
  output logic [31:0] out_sec_bytes,
  output logic [31:0] out_total_packets,
  output logic [31:0] out_total_lost,
  output logic [31:0] out_total_late,
  output logic [21:0] out_total_kbytes
);

  localparam int N  = MAX_SENDERS;
  localparam int CW = COUNT_WIDTH;
  localparam int DW = 8 * CW + 43;
  localparam int WW = $clog2(N);        // walk position
  localparam int UW = $clog2(N + 1);    // used-slot count

  // configuration registers
  logic [7:0]  overhead_r;
  logic [15:0] max_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overhead_r <= OVERHEAD_RST;
      max_len_r  <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_OVERHEAD: overhead_r <= cfg_data[7:0];
        CFG_IDX_MAX_LEN:  max_len_r  <= cfg_data;
        default:          ;
      endcase
    end
  end

  // control
  rslm_state_t   state_r, state_nxt;
  logic [WW-1:0] walk_r, walk_nxt;
  logic [UW-1:0] used_cnt_r, used_cnt_nxt;

  // registered packet request
  logic [31:0] p_addr_r;
  logic [7:0]  p_seq_r;
  logic        p_seq_valid_r;
  logic [15:0] p_len_r;
  logic        in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_addr_r      <= in_source_addr;
      p_seq_r       <= in_seq_byte;
      p_seq_valid_r <= in_seq_valid;
      p_len_r       <= in_pkt_length;
    end
  end

  // cell row
  cell_ctl_t      ctl;
  logic [N-1:0]   hit, free_chain, active;
  logic [DW-1:0]  cell_q [N];
  logic [DW-1:0]  tail;
  logic           any_hit, any_free;
  logic           step_en;

  assign any_hit  = |hit;
  assign any_free = free_chain[N-1];

  for (genvar i = 0; i < N; i++) begin : g_cell
    rslm_cell #(.CW(CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .free_in   ((i == 0) ? 1'b0 : free_chain[(i == 0) ? 0 : i - 1]),
      .free_out  (free_chain[i]),
      .hit       (hit[i]),
      .nxt_in    ((i == N - 1) ? tail : cell_q[(i == N - 1) ? i : i + 1]),
      .cur_out   (cell_q[i]),
      .active_out(active[i])
    );
  end

  // head of the row folds into totals
  logic               row_emit;
  logic [31:0]        row_addr;
  logic [3:0][CW-1:0] row_sec, row_tot, grand;

  rslm_fold #(.CW(CW)) u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .head    (cell_q[0]),
    .tail    (tail),
    .row_emit(row_emit),
    .row_addr(row_addr),
    .row_sec (row_sec),
    .row_tot (row_tot),
    .grand   (grand)
  );

  logic [16:0] clamp_len;
  assign clamp_len = (p_len_r > max_len_r) ? {1'b0, max_len_r} : {1'b0, p_len_r};

  // no active slot behind the head means the head's row ends the tick
  logic rest_active;
  always_comb begin
    rest_active = 1'b0;
    for (int j = 1; j < N; j++) rest_active = rest_active | active[j];
  end

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        o_total_r, o_last_r;
  logic [31:0] o_addr_r;
  logic [3:0][CW-1:0] o_sec_r, o_tot_r;
  logic        out_free, load_total, load_row;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    walk_nxt     = walk_r;
    used_cnt_nxt = used_cnt_r;
    ctl          = '0;
    ctl.addr     = p_addr_r;
    ctl.seq      = p_seq_r;
    ctl.seq_valid= p_seq_valid_r;
    ctl.bytes    = clamp_len + 17'(overhead_r);
    ctl.miss     = !any_hit;
    step_en      = 1'b0;
    load_total   = 1'b0;
    load_row     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        walk_nxt = '0;
        if (in_acc) begin
          if (!in_kind) state_nxt = ST_PKT;
          else if (in_new_minute && used_cnt_r > UW'(1)) state_nxt = ST_TOTAL;
          else state_nxt = ST_WALK;
        end
      end
      ST_PKT: begin
        ctl.pkt_en = 1'b1;
        if (!any_hit && any_free) used_cnt_nxt = used_cnt_r + UW'(1);
        state_nxt = ST_IDLE;
      end
      ST_TOTAL: begin
        if (out_free) begin
          load_total = 1'b1;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          step_en      = 1'b1;
          ctl.shift_en = 1'b1;
          load_row     = row_emit;
          walk_nxt     = walk_r + WW'(1);
          if (walk_r == WW'(N - 1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (load_total || load_row) ? 1'b1 :
                         (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_r      <= '0;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_total) begin
      o_total_r <= 1'b1;
      o_last_r  <= !(|active);
      o_addr_r  <= '0;
      o_sec_r   <= '0;
      o_tot_r   <= grand;
    end else if (load_row) begin
      o_total_r <= 1'b0;
      o_last_r  <= !rest_active;
      o_addr_r  <= row_addr;
      o_sec_r   <= row_sec;
      o_tot_r   <= row_tot;
    end
  end

  logic [CW-1:0] kb_full;
  assign kb_full = o_tot_r[3] >> KB_SHIFT;

  assign out_valid         = out_valid_r;
  assign out_is_total_row  = o_total_r;
  assign out_is_last       = o_last_r;
  assign out_sender_addr   = o_addr_r;
  assign out_sec_packets   = 32'(o_sec_r[0]);
  assign out_sec_lost      = 32'(o_sec_r[1]);
  assign out_sec_late      = 32'(o_sec_r[2]);
  assign out_sec_bytes     = 32'(o_sec_r[3]);
  assign out_total_packets = 32'(o_tot_r[0]);
  assign out_total_lost    = 32'(o_tot_r[1]);
  assign out_total_late    = 32'(o_tot_r[2]);
  assign out_total_kbytes  = (kb_full > CW'(KB_MAX)) ? KB_MAX : 22'(kb_full);

endmodule

// File: rtl/rslm_cell.sv
`timescale 1ns / 1ps
module rslm_cell import rslm_pkg::*; #(
  parameter int CW = COUNT_WIDTH_DEF,
  localparam int DW = 8 * CW + 43
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctl_t     ctl,
  input  logic          free_in,
  output logic          free_out,
  output logic          hit,
  input  logic [DW-1:0] nxt_in,
  output logic [DW-1:0] cur_out,
  output logic          active_out
);

  localparam int SW = ((CW > 17) ? CW : 17) + 1;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                           input logic [SW-2:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > {{(SW-CW){1'b0}}, {CW{1'b1}}}) return {CW{1'b1}};
    return s[CW-1:0];
  endfunction

  logic                used_r, used_nxt;
  logic [31:0]         addr_r, addr_nxt;
  logic                known_r, known_nxt;
  logic [7:0]          last_r, last_nxt;
  logic                active_r, active_nxt;
  logic [3:0][CW-1:0]  sec_r, sec_nxt;
  logic [3:0][CW-1:0]  tot_r, tot_nxt;

  logic                alloc, sel;
  logic [7:0]          d;
  logic                known_b;
  logic [3:0][CW-1:0]  sec_b;

  assign hit        = used_r && (addr_r == ctl.addr);
  assign free_out   = free_in | ~used_r;
  assign alloc      = ctl.pkt_en && ctl.miss && !used_r && !free_in;
  assign sel        = (ctl.pkt_en && hit) || alloc;
  assign active_out = active_r;
  assign cur_out    = {used_r, addr_r, known_r, last_r, active_r, sec_r, tot_r};

  always_comb begin
    used_nxt   = used_r;
    addr_nxt   = addr_r;
    known_nxt  = known_r;
    last_nxt   = last_r;
    active_nxt = active_r;
    sec_nxt    = sec_r;
    tot_nxt    = tot_r;
    known_b    = alloc ? 1'b0 : known_r;
    sec_b      = alloc ? '0 : sec_r;
    d          = ctl.seq - last_r - 8'd1;
    if (ctl.shift_en) begin
      {used_nxt, addr_nxt, known_nxt, last_nxt, active_nxt, sec_nxt, tot_nxt} = nxt_in;
    end else if (sel) begin
      used_nxt   = 1'b1;
      addr_nxt   = ctl.addr;
      known_nxt  = known_b;
      active_nxt = alloc ? 1'b0 : active_r;
      sec_nxt    = sec_b;
      if (alloc) tot_nxt = '0;
      if (ctl.seq_valid) begin
        active_nxt = 1'b1;
        sec_nxt[0] = sat_add(sec_b[0], (SW-1)'(1));
        if (known_b) begin
          if (d[7]) begin
            sec_nxt[2] = sat_add(sec_b[2], (SW-1)'(1));
          end else begin
            sec_nxt[1] = sat_add(sec_b[1], (SW-1)'(d));
            last_nxt   = ctl.seq;
          end
        end else begin
          last_nxt  = ctl.seq;
          known_nxt = 1'b1;
        end
      end else begin
        sec_nxt[2] = sat_add(sec_b[2], (SW-1)'(1));
      end
      sec_nxt[3] = sat_add(sec_b[3], (SW-1)'(ctl.bytes));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= 1'b0;
      known_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      known_r  <= known_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    last_r <= last_nxt;
    sec_r  <= sec_nxt;
    tot_r  <= tot_nxt;
  end

endmodule

// File: rtl/rslm_fold.sv
`timescale 1ns / 1ps
module rslm_fold import rslm_pkg::*; #(
  parameter int CW = COUNT_WIDTH_DEF,
  localparam int DW = 8 * CW + 43
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [DW-1:0]      head,
  output logic [DW-1:0]      tail,
  output logic               row_emit,
  output logic [31:0]        row_addr,
  output logic [3:0][CW-1:0] row_sec,
  output logic [3:0][CW-1:0] row_tot,
  output logic [3:0][CW-1:0] grand
);

  localparam int SW = CW + 1;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                           input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s[CW]) return {CW{1'b1}};
    return s[CW-1:0];
  endfunction

  logic               h_used, h_known, h_active;
  logic [31:0]        h_addr;
  logic [7:0]         h_last;
  logic [3:0][CW-1:0] h_sec, h_tot, tot_new;
  logic [3:0][CW-1:0] grand_r, grand_nxt;

  assign {h_used, h_addr, h_known, h_last, h_active, h_sec, h_tot} = head;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tot_new[k]   = sat_add(h_tot[k], h_sec[k]);
      grand_nxt[k] = sat_add(grand_r[k], h_sec[k]);
    end
  end

  // A used slot leaves the head folded and cleared; a free one passes as is.
  assign tail = h_used ? {h_used, h_addr, h_known, h_last, 1'b0, {(4*CW){1'b0}}, tot_new}
                       : head;

  assign row_emit = h_used && h_active;
  assign row_addr = h_addr;
  assign row_sec  = h_sec;
  assign row_tot  = tot_new;
  assign grand    = grand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grand_r <= '0;
    end else if (step_en && h_used) begin
      grand_r <= grand_nxt;
    end
  end

endmodule
